### rtl/core/rra_pkg.sv
// Shared types and constants for the register run allocator.
// No dependencies; imported by rra_cell and register_run_allocator.
`default_nettype none

package rra_pkg;

    localparam int NUM_REGS   = 256;
    localparam int MAX_WIDTH  = 4;
    localparam int CELL_BITS  = 32;
    localparam int NUM_CELLS  = NUM_REGS / CELL_BITS;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int WID_W      = 3;
    localparam int CELL_AW    = $clog2(CELL_BITS);
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int CARRY_W    = MAX_WIDTH - 1;

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_ALLOC_AT = 2'd1;
    localparam logic [1:0] OP_FREE     = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } rra_state_t;

    // range command broadcast to every cell
    typedef struct packed {
        logic               en;
        logic               set;
        logic [IDX_W-1:0]   pos;
        logic [WID_W-1:0]   width;
    } rra_cmd_t;

endpackage

`default_nettype wire

### rtl/core/register_run_allocator.sv
// Top level of the register run allocator: control FSM and the row of map cells.
// Depends on rra_pkg and rra_cell.
`default_nettype none

// Keeps one free bit per register in a row of NUM_CELLS cells of CELL_BITS bits
// and a high-water file size. Free, allocate-at and query go from idle to the
// execute state; the result is registered when that state completes, and the
// next request is taken once the block is back in idle. A first-fit allocate
// first runs a search in which the token visits k cells (1 to NUM_CELLS, 8 here),
// one per cycle, the cell holding the fit included; a search with no fit visits
// all of them. A finished result held off on the output delays the next result.
// One transaction is in work at a time; a finished result waits in the output
// register while the next is accepted.

module register_run_allocator
    import rra_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [IDX_W-1:0]  reg_position,
    input  wire logic [WID_W-1:0]  run_width,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [IDX_W-1:0]       reg_index,
    output logic                   status,
    output logic                   range_free,
    output logic [SIZE_W-1:0]      used_size
);

    rra_state_t         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [WID_W-1:0]   width_reg, width_next;
    logic               miss_reg, miss_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               status_reg, status_next;
    logic               rfree_reg, rfree_next;

    logic [NUM_CELLS:0]     tok;
    logic [CARRY_W-1:0]     carry [NUM_CELLS+1];
    logic [NUM_CELLS-1:0]   hits;
    logic [NUM_CELLS-1:0]   rng;
    logic [IDX_W-1:0]       starts [NUM_CELLS];
    logic [IDX_W-1:0]       hit_pos;
    rra_cmd_t               cmd;

    logic               accept;
    logic               width_ok;
    logic               go;
    logic               refused;
    logic [SIZE_W-1:0]  end9;

    assign accept   = req_valid & ~req_stall;
    assign width_ok = (run_width != '0) && (run_width <= WID_W'(MAX_WIDTH));
    assign go       = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign end9     = {1'b0, pos_reg} + SIZE_W'(width_reg);
    assign refused  = (op_reg == OP_ALLOC) ? miss_reg :
                      ((width_reg == '0) || (width_reg > WID_W'(MAX_WIDTH)) ||
                       (end9 > SIZE_W'(NUM_REGS)));

    assign tok[0]   = accept && (operation == OP_ALLOC) && width_ok;
    assign carry[0] = '0;

    always_comb
    begin
        hit_pos = '0;
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            hit_pos = hit_pos | starts[k];
        end
    end

    always_comb
    begin
        cmd.en    = go && !refused && (op_reg != OP_QUERY);
        cmd.set   = (op_reg == OP_FREE);
        cmd.pos   = pos_reg;
        cmd.width = width_reg;
    end

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        rra_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (CELL_IDX_W'(k)),
            .tok_in    (tok[k]),
            .tok_out   (tok[k+1]),
            .carry_in  (carry[k]),
            .carry_out (carry[k+1]),
            .cmd       (cmd),
            .hit       (hits[k]),
            .hit_start (starts[k]),
            .rng_free  (rng[k])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        width_next     = width_reg;
        miss_next      = miss_reg;
        size_next      = size_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        index_next     = index_reg;
        status_next    = status_reg;
        rfree_next     = rfree_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = operation;
                    pos_next   = reg_position;
                    width_next = run_width;
                    miss_next  = ~width_ok;
                    if ((operation == OP_ALLOC) && width_ok)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                if (|hits)
                begin
                    pos_next   = hit_pos;
                    state_next = S_EXEC;
                end
                else if (tok[NUM_CELLS])
                begin
                    miss_next  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = refused;
                    rfree_next     = (op_reg == OP_QUERY) && !refused && (&rng);
                    index_next     = ((op_reg == OP_ALLOC) && refused) ? '0 : pos_reg;
                    if (!refused && ((op_reg == OP_ALLOC) || (op_reg == OP_ALLOC_AT)) &&
                        (end9 > size_reg))
                    begin
                        size_next = end9;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        width_reg <= width_next;
        miss_reg  <= miss_next;
        index_reg <= index_next;
        status_reg <= status_next;
        rfree_reg <= rfree_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign reg_index  = index_reg;
    assign status     = status_reg;
    assign range_free = rfree_reg;
    assign used_size  = size_reg;

    // at most one search token in the row
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok[NUM_CELLS-1:0]))
        else $error("more than one search token");

    // a fit is only reported during a search
    assert property (@(posedge clk) disable iff (!rst_n) (|hits) |-> (state_reg == S_SCAN))
        else $error("cell hit outside scan");

    // an accepted transaction always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (state_reg != S_IDLE))
        else $error("accepted transaction dropped");

    // file size never passes the store
    assert property (@(posedge clk) disable iff (!rst_n) size_reg <= SIZE_W'(NUM_REGS))
        else $error("file size beyond store");

endmodule

`default_nettype wire

### rtl/core/rra_cell.sv
// One slice of the free map: CELL_BITS bits, first-fit search with a passing token.
// Depends on rra_pkg.
`default_nettype none

module rra_cell
    import rra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CELL_IDX_W-1:0] cell_idx,
    input  wire logic                  tok_in,
    output logic                       tok_out,
    input  wire logic [CARRY_W-1:0]    carry_in,
    output logic [CARRY_W-1:0]         carry_out,
    input  wire rra_cmd_t              cmd,
    output logic                       hit,
    output logic [IDX_W-1:0]           hit_start,
    output logic                       rng_free
);

    logic [CELL_BITS-1:0]         map_reg, map_next;
    logic                         tok_reg;
    logic [CELL_BITS+CARRY_W-1:0] ext;
    logic [MAX_WIDTH-1:0]         wmask;
    logic [CELL_BITS-1:0]         fit;
    logic [CELL_BITS-1:0]         rmask;
    logic                         found;
    logic [CELL_AW-1:0]           first;
    logic [IDX_W:0]               start9;
    logic [IDX_W:0]               end9;
    logic [IDX_W:0]               g9;

    assign ext       = {map_reg, carry_in};
    assign carry_out = map_reg[CELL_BITS-1 -: CARRY_W];

    always_comb
    begin
        for (int b = 0; b < MAX_WIDTH; b++)
        begin
            wmask[b] = (WID_W'(MAX_WIDTH - b) <= cmd.width);
        end
        for (int j = 0; j < CELL_BITS; j++)
        begin
            fit[j] = &(ext[j +: MAX_WIDTH] | ~wmask);
        end
    end

    always_comb
    begin
        found = 1'b0;
        first = '0;
        for (int j = 0; j < CELL_BITS; j++)
        begin
            if (!found && fit[j])
            begin
                found = 1'b1;
                first = CELL_AW'(j);
            end
        end
    end

    assign start9    = {1'b0, cell_idx, first} + (IDX_W+1)'(1) - (IDX_W+1)'(cmd.width);
    assign hit       = tok_reg & found;
    assign hit_start = hit ? start9[IDX_W-1:0] : '0;
    assign tok_out   = tok_reg & ~found;

    assign end9 = {1'b0, cmd.pos} + (IDX_W+1)'(cmd.width);

    always_comb
    begin
        g9 = '0;
        for (int i = 0; i < CELL_BITS; i++)
        begin
            g9       = {1'b0, cell_idx, CELL_AW'(i)};
            rmask[i] = (g9 >= {1'b0, cmd.pos}) && (g9 < end9);
        end
    end

    assign rng_free = &(map_reg | ~rmask);

    always_comb
    begin
        map_next = map_reg;
        if (cmd.en)
        begin
            if (cmd.set)
            begin
                map_next = map_reg | rmask;
            end
            else
            begin
                map_next = map_reg & ~rmask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '1;
            tok_reg <= 1'b0;
        end
        else
        begin
            map_reg <= map_next;
            tok_reg <= tok_in;
        end
    end

endmodule

`default_nettype wire
